@@ hdl/vlxf_pkg.sv @@
// Shared types, widths and codes of the velocity layer crossfade mixer.
`timescale 1ns / 1ps

package vlxf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int VEL_W       = 7;
  localparam int ZONE_W      = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = VEL_W;

  // divider: quotient bits split evenly over the divider stages
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEPS   = (SAMPLE_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int QUO_W       = DIV_STAGES * DIV_STEPS;
  localparam int REM_W       = VEL_W;
  localparam int MAG_W       = QUO_W + REM_W;
  localparam int NUM_W       = SAMPLE_BITS + VEL_W + 1;

  // select, multiply, magnitude, divider stages, output
  localparam int PIPE_STAGES = DIV_STAGES + 4;

  localparam logic [VEL_W-1:0] SOFT_FADE_START_RST = VEL_W'(8);
  localparam logic [VEL_W-1:0] SOFT_FADE_END_RST   = VEL_W'(59);
  localparam logic [VEL_W-1:0] HARD_FADE_START_RST = VEL_W'(67);
  localparam logic [VEL_W-1:0] HARD_FADE_END_RST   = VEL_W'(119);

  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FADE_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FADE_END   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_FADE_START = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_FADE_END   = CFG_IDX_W'(3);

  typedef enum logic [ZONE_W-1:0] {
    ZONE_SOFT      = 3'd0,
    ZONE_SOFT_MED  = 3'd1,
    ZONE_MED       = 3'd2,
    ZONE_MED_HARD  = 3'd3,
    ZONE_HARD      = 3'd4,
    ZONE_RELEASE   = 3'd5
  } zone_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // partial remainder on top, dividend bits shifting out / quotient bits in below
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] work;
  } div_t;

  // per-item control carried along the pipe
  typedef struct packed {
    zone_t            zone;
    logic             last;
    logic             fade;
    logic             neg_l;
    logic             neg_r;
    logic [VEL_W-1:0] span;
    sample_t          pass_l;
    sample_t          pass_r;
  } side_t;

endpackage

@@ hdl/vlxf_if.sv @@
// Stream and configuration interfaces of the crossfade mixer.
`timescale 1ns / 1ps

interface vlxf_layers_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 key_down;
  logic [vlxf_pkg::VEL_W-1:0]           velocity;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] soft_left;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] soft_right;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] medium_left;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] medium_right;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] hard_left;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] hard_right;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] release_left;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] release_right;
  logic                                 last_frame;

  modport source (
    output valid, key_down, velocity, soft_left, soft_right, medium_left, medium_right,
           hard_left, hard_right, release_left, release_right, last_frame,
    input  ready
  );
  modport sink (
    input  valid, key_down, velocity, soft_left, soft_right, medium_left, medium_right,
           hard_left, hard_right, release_left, release_right, last_frame,
    output ready
  );
endinterface

interface vlxf_mix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] mix_left;
  logic signed [vlxf_pkg::SAMPLE_BITS-1:0] mix_right;
  logic [vlxf_pkg::ZONE_W-1:0]          zone;
  logic                                 last_out;

  modport source (output valid, mix_left, mix_right, zone, last_out, input ready);
  modport sink (input valid, mix_left, mix_right, zone, last_out, output ready);
endinterface

interface vlxf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vlxf_pkg::CFG_IDX_W-1:0]   index;
  logic [vlxf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/vlxf_div_stage.sv @@
// One registered stage of the restoring divider: DIV_STEPS quotient bits per stage.
`timescale 1ns / 1ps

module vlxf_div_stage (
  input  logic                          clk,
  input  logic                          en,
  input  vlxf_pkg::div_t                d_in,
  input  logic [vlxf_pkg::REM_W-1:0]    divisor,
  output vlxf_pkg::div_t                d_out
);

  vlxf_pkg::div_t                cur;
  logic [vlxf_pkg::REM_W:0]      trial;

  always_comb begin
    cur   = d_in;
    trial = '0;
    for (int i = 0; i < vlxf_pkg::DIV_STEPS; i++) begin
      trial = {cur.rem, cur.work[vlxf_pkg::QUO_W-1]};
      if (trial >= {1'b0, divisor}) begin
        cur.rem  = vlxf_pkg::REM_W'(trial - {1'b0, divisor});
        cur.work = {cur.work[vlxf_pkg::QUO_W-2:0], 1'b1};
      end else begin
        cur.rem  = trial[vlxf_pkg::REM_W-1:0];
        cur.work = {cur.work[vlxf_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= cur;
    end
  end

endmodule

@@ hdl/velocity_layer_crossfade_mixer_unit.sv @@
// Top level of the velocity layer crossfade mixer.
`timescale 1ns / 1ps
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  layers  | in  | valid/ready | key_down, velocity, 4 stereo layer samples, last_frame
//  mix     | out | valid/ready | mix_left, mix_right, zone, last_out
//  cfg     | in  | valid/ready | index, data (four 7-bit velocity thresholds)
//
//  One frame per cycle sustained while mix is ready; the layers transfer reaches
//  the mix result through the PIPE_STAGES registers in order: select, multiply,
//  magnitude, the four divider stages and the output register.
//  Synchronous active-high reset clears the valid bits and loads the default
//  thresholds. cfg is always ready.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles are squeezed out and a stall on mix holds every item in place.

module velocity_layer_crossfade_mixer_unit (
  input logic           clk,
  input logic           rst,
  vlxf_layers_if.sink   layers,
  vlxf_mix_if.source    mix,
  vlxf_cfg_if.sink      cfg
);

  localparam int LAST = vlxf_pkg::PIPE_STAGES - 1;
  localparam int DS   = vlxf_pkg::DIV_STAGES;

  // Velocity thresholds
  logic [vlxf_pkg::VEL_W-1:0] soft_start, soft_end, hard_start, hard_end;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_start <= vlxf_pkg::SOFT_FADE_START_RST;
      soft_end   <= vlxf_pkg::SOFT_FADE_END_RST;
      hard_start <= vlxf_pkg::HARD_FADE_START_RST;
      hard_end   <= vlxf_pkg::HARD_FADE_END_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        vlxf_pkg::CFG_SOFT_FADE_START: soft_start <= cfg.data;
        vlxf_pkg::CFG_SOFT_FADE_END:   soft_end   <= cfg.data;
        vlxf_pkg::CFG_HARD_FADE_START: hard_start <= cfg.data;
        vlxf_pkg::CFG_HARD_FADE_END:   hard_end   <= cfg.data;
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // Pipe control: per-stage valid and advance
  logic [vlxf_pkg::PIPE_STAGES-1:0] vld;
  logic [vlxf_pkg::PIPE_STAGES-1:0] en;
  vlxf_pkg::side_t                  side [vlxf_pkg::PIPE_STAGES];

  always_comb begin
    en[LAST] = !vld[LAST] || mix.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign layers.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < vlxf_pkg::PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? layers.valid : vld[k-1 < 0 ? 0 : k-1];
        end
      end
    end
  end

  // Stage 0: zone decode and operand select.
  // Threshold tests run in fixed order, so a zone with non-increasing bounds
  // is never picked and a chosen fade always has hi > lo.
  vlxf_pkg::side_t              side_in;
  vlxf_pkg::sample_t            sel_a_l, sel_a_r, sel_b_l, sel_b_r;
  logic [vlxf_pkg::VEL_W-1:0]   sel_lo, sel_hi;

  always_comb begin
    side_in        = '0;
    side_in.last   = layers.last_frame;
    sel_a_l        = layers.soft_left;
    sel_a_r        = layers.soft_right;
    sel_b_l        = layers.medium_left;
    sel_b_r        = layers.medium_right;
    sel_lo         = soft_start;
    sel_hi         = soft_end;
    priority if (!layers.key_down) begin
      side_in.zone = vlxf_pkg::ZONE_RELEASE;
      sel_a_l      = layers.release_left;
      sel_a_r      = layers.release_right;
    end else if (layers.velocity <= soft_start) begin
      side_in.zone = vlxf_pkg::ZONE_SOFT;
    end else if (layers.velocity <= soft_end) begin
      side_in.zone = vlxf_pkg::ZONE_SOFT_MED;
      side_in.fade = 1'b1;
    end else if (layers.velocity <= hard_start) begin
      side_in.zone = vlxf_pkg::ZONE_MED;
      sel_a_l      = layers.medium_left;
      sel_a_r      = layers.medium_right;
    end else if (layers.velocity <= hard_end) begin
      side_in.zone = vlxf_pkg::ZONE_MED_HARD;
      side_in.fade = 1'b1;
      sel_a_l      = layers.medium_left;
      sel_a_r      = layers.medium_right;
      sel_b_l      = layers.hard_left;
      sel_b_r      = layers.hard_right;
      sel_lo       = hard_start;
      sel_hi       = hard_end;
    end else begin
      side_in.zone = vlxf_pkg::ZONE_HARD;
      sel_a_l      = layers.hard_left;
      sel_a_r      = layers.hard_right;
    end
    side_in.span   = sel_hi - sel_lo;
    side_in.pass_l = sel_a_l;
    side_in.pass_r = sel_a_r;
  end

  vlxf_pkg::sample_t            a_l, a_r, b_l, b_r;
  logic [vlxf_pkg::VEL_W-1:0]   wa, wb;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_l <= sel_a_l;
      a_r <= sel_a_r;
      b_l <= sel_b_l;
      b_r <= sel_b_r;
      wa  <= sel_hi - layers.velocity;
      wb  <= layers.velocity - sel_lo;
    end
  end

  // Stage 1: weighted sum a*(hi-v) + b*(v-lo)
  logic signed [vlxf_pkg::NUM_W-1:0] num_l, num_r;
  logic signed [vlxf_pkg::NUM_W-1:0] wa_s, wb_s;

  assign wa_s = vlxf_pkg::NUM_W'($signed({1'b0, wa}));
  assign wb_s = vlxf_pkg::NUM_W'($signed({1'b0, wb}));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_l <= vlxf_pkg::NUM_W'(a_l) * wa_s + vlxf_pkg::NUM_W'(b_l) * wb_s;
      num_r <= vlxf_pkg::NUM_W'(a_r) * wa_s + vlxf_pkg::NUM_W'(b_r) * wb_s;
    end
  end

  // Stage 2: sign and magnitude, loaded as the divider's starting word
  logic signed [vlxf_pkg::NUM_W-1:0] abs_l, abs_r;
  vlxf_pkg::side_t                   side_abs;
  vlxf_pkg::div_t                    div_l [DS+1];
  vlxf_pkg::div_t                    div_r [DS+1];

  assign abs_l = num_l[vlxf_pkg::NUM_W-1] ? -num_l : num_l;
  assign abs_r = num_r[vlxf_pkg::NUM_W-1] ? -num_r : num_r;

  always_comb begin
    side_abs       = side[1];
    side_abs.neg_l = num_l[vlxf_pkg::NUM_W-1];
    side_abs.neg_r = num_r[vlxf_pkg::NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_l[0] <= vlxf_pkg::div_t'(vlxf_pkg::MAG_W'(unsigned'(abs_l)));
      div_r[0] <= vlxf_pkg::div_t'(vlxf_pkg::MAG_W'(unsigned'(abs_r)));
    end
  end

  // Side band travels with every stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_in;
    end
    for (int k = 1; k < vlxf_pkg::PIPE_STAGES; k++) begin
      if (en[k]) begin
        side[k] <= (k == 2) ? side_abs : side[k-1];
      end
    end
  end

  // Stages 3 .. 3+DS-1: restoring division by the fade span
  for (genvar j = 0; j < DS; j++) begin : g_div
    vlxf_div_stage u_div_l (
      .clk     (clk),
      .en      (en[3+j]),
      .d_in    (div_l[j]),
      .divisor (side[2+j].span),
      .d_out   (div_l[j+1])
    );
    vlxf_div_stage u_div_r (
      .clk     (clk),
      .en      (en[3+j]),
      .d_in    (div_r[j]),
      .divisor (side[2+j].span),
      .d_out   (div_r[j+1])
    );
  end

  // Output stage: restore sign, clamp, or pass the single layer through
  function automatic vlxf_pkg::sample_t sign_sat(input logic [vlxf_pkg::QUO_W-1:0] q,
                                                 input logic neg);
    logic [vlxf_pkg::QUO_W-1:0] pos_max;
    logic [vlxf_pkg::QUO_W-1:0] neg_max;
    logic [vlxf_pkg::SAMPLE_BITS-1:0] low;
    pos_max = vlxf_pkg::QUO_W'((64'd1 << (vlxf_pkg::SAMPLE_BITS - 1)) - 64'd1);
    neg_max = vlxf_pkg::QUO_W'(64'd1 << (vlxf_pkg::SAMPLE_BITS - 1));
    low     = q[vlxf_pkg::SAMPLE_BITS-1:0];
    if (!neg && q > pos_max) begin
      return vlxf_pkg::sample_t'(pos_max[vlxf_pkg::SAMPLE_BITS-1:0]);
    end else if (neg && q > neg_max) begin
      return vlxf_pkg::sample_t'(neg_max[vlxf_pkg::SAMPLE_BITS-1:0]);
    end else if (neg) begin
      return vlxf_pkg::sample_t'(-low);
    end
    return vlxf_pkg::sample_t'(low);
  endfunction

  vlxf_pkg::sample_t out_l, out_r;

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_l <= side[LAST-1].fade ? sign_sat(div_l[DS].work, side[LAST-1].neg_l)
                                 : side[LAST-1].pass_l;
      out_r <= side[LAST-1].fade ? sign_sat(div_r[DS].work, side[LAST-1].neg_r)
                                 : side[LAST-1].pass_r;
    end
  end

  assign mix.valid     = vld[LAST];
  assign mix.mix_left  = out_l;
  assign mix.mix_right = out_r;
  assign mix.zone      = side[LAST].zone;
  assign mix.last_out  = side[LAST].last;

endmodule

@@ hdl/vlxf_checker.sv @@
// Port-level checks of the crossfade mixer, bound to the top level.
`timescale 1ns / 1ps

module vlxf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  layers_valid,
  input logic                                  layers_ready,
  input logic                                  mix_valid,
  input logic                                  mix_ready,
  input logic signed [vlxf_pkg::SAMPLE_BITS-1:0] mix_left,
  input logic signed [vlxf_pkg::SAMPLE_BITS-1:0] mix_right,
  input logic [vlxf_pkg::ZONE_W-1:0]           mix_zone,
  input logic                                  mix_last
);

  // stalled result holds
  a_mix_hold: assert property (@(posedge clk) disable iff (rst)
    mix_valid && !mix_ready |=> mix_valid && $stable(mix_left) && $stable(mix_right)
      && $stable(mix_zone) && $stable(mix_last))
    else $error("mix result changed while stalled");

  // input is refused only when the full pipe is blocked at the output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !layers_ready |-> mix_valid && !mix_ready)
    else $error("layers not ready without output backpressure");

  // no result can emerge sooner than the pipe depth after reset
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    mix_valid |-> !($past(rst, 1) || $past(rst, 2) || $past(rst, 3) || $past(rst, 4)
      || $past(rst, 5) || $past(rst, 6) || $past(rst, 7)))
    else $error("result appeared before pipe latency after reset");

  // nothing leaves the pipe directly after reset, whatever the input
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !mix_valid)
    else $error("result valid directly after reset");

endmodule

bind velocity_layer_crossfade_mixer_unit vlxf_checker u_vlxf_checker (
  .clk          (clk),
  .rst          (rst),
  .layers_valid (layers.valid),
  .layers_ready (layers.ready),
  .mix_valid    (mix.valid),
  .mix_ready    (mix.ready),
  .mix_left     (mix.mix_left),
  .mix_right    (mix.mix_right),
  .mix_zone     (mix.zone),
  .mix_last     (mix.last_out)
);
